// ----- src/slibm_pkg.sv -----
// Shared types and constants for the scanline interrupt bank mapper.
// Used by slibm_irq_counter and scanline_irq_bank_mapper; depends on nothing.

package slibm_pkg;

   // Request kinds carried in req_tuser
   localparam logic [1:0] CMD_BUS_WRITE = 2'd0;
   localparam logic [1:0] CMD_SCANLINE  = 2'd1;
   localparam logic [1:0] CMD_QUERY     = 2'd2;
   localparam logic [1:0] CMD_RESET     = 2'd3;

   // Configuration register indexes
   localparam logic CSR_PRG_BANK_COUNT  = 1'b0;
   localparam logic CSR_CHR_ROM_PRESENT = 1'b1;

   localparam logic [8:0] PRG_BANK_COUNT_RESET  = 9'd32;
   localparam logic       CHR_ROM_PRESENT_RESET = 1'b1;

   // Decoded bus addresses
   localparam logic [15:0] ADDR_MIRROR_SINGLE = 16'h42FE;
   localparam logic [15:0] ADDR_MIRROR_DUAL   = 16'h42FF;
   localparam logic [15:0] ADDR_IRQ_DISABLE   = 16'h4501;
   localparam logic [15:0] ADDR_LATCH_LO      = 16'h4502;
   localparam logic [15:0] ADDR_LATCH_HI      = 16'h4503;
   localparam logic [15:0] ADDR_CPU_BANK_BASE = 16'h4504;
   localparam logic [15:0] ADDR_CHR_BANK_BASE = 16'h4510;

   // Scanline counter step and the threshold that fires the interrupt
   localparam logic [15:0] TICK_STEP  = 16'd113;
   localparam logic [15:0] TICK_LIMIT = 16'hFFFF - TICK_STEP;

   // Mirroring modes
   localparam logic [1:0] MIRROR_SINGLE_A = 2'd0;
   localparam logic [1:0] MIRROR_SINGLE_B = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL = 2'd2;
   localparam logic [1:0] MIRROR_HORIZ    = 2'd3;

   // Strobes from the decoder to the interrupt counter, valid on an accepted request
   typedef struct packed {
      logic clear;
      logic disarm;
      logic load_lo;
      logic load_hi;
      logic tick;
   } irq_ctl_type;

   // Interrupt counter status after the current request
   typedef struct packed {
      logic pulse;
      logic armed;
   } irq_stat_type;

endpackage

// ----- src/slibm_irq_counter.sv -----
// Scanline interrupt counter with its 16-bit reload latch and enable.
// Depends on slibm_pkg for the strobe and status structs and the tick constants.

module slibm_irq_counter
   import slibm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  irq_ctl_type  ctl,
   input  logic [7:0]   data,
   output irq_stat_type stat
);

   logic [15:0] count_ff, count_in;
   logic [15:0] latch_ff, latch_in;
   logic        armed_ff, armed_in;
   logic        pulse;

   always_comb begin
      count_in = count_ff;
      latch_in = latch_ff;
      armed_in = armed_ff;
      pulse    = 1'b0;
      if (ctl.clear) begin
         count_in = '0;
         latch_in = '0;
         armed_in = 1'b0;
      end else if (ctl.disarm) begin
         armed_in = 1'b0;
      end else if (ctl.load_lo) begin
         latch_in = {latch_ff[15:8], data};
      end else if (ctl.load_hi) begin
         latch_in = {data, latch_ff[7:0]};
         count_in = {data, latch_ff[7:0]};
         armed_in = 1'b1;
      end else if (ctl.tick && armed_ff) begin
         if (count_ff >= TICK_LIMIT) begin
            pulse    = 1'b1;
            count_in = '0;
            armed_in = 1'b0;
         end else begin
            count_in = count_ff + TICK_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         latch_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         latch_ff <= latch_in;
         armed_ff <= armed_in;
      end
   end

   assign stat.pulse = pulse;
   assign stat.armed = armed_in;

`ifndef SYNTHESIS
   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (ctl.tick && !armed_ff) |=> $stable(count_ff))
      else $error("counter moved on a tick while disarmed");
   a_pulse_clears: assert property (@(posedge clock) disable iff (reset)
      pulse |=> (count_ff == 16'd0) && !armed_ff)
      else $error("interrupt did not clear and disarm the counter");
   a_reload: assert property (@(posedge clock) disable iff (reset)
      ctl.load_hi |=> armed_ff && (count_ff == latch_ff))
      else $error("high latch write did not reload and arm the counter");
`endif

endmodule

// ----- src/scanline_irq_bank_mapper.sv -----
// Top level of the scanline interrupt bank mapper: decoder, bank registers and result register.
// Depends on slibm_pkg and instantiates slibm_irq_counter.

// The block takes one request per cycle on the req_ channel: req_tuser holds the kind
// (bus write, scanline tick, bank query or mapper reset) and req_tdata the bus address,
// data byte and query slot. Each request yields exactly one response on rsp_: the
// interrupt pulse, the mirroring mode and enable after the request, and the queried
// bank value (zero for other kinds).
// All state is updated in the cycle a request is accepted, and the response appears in
// the output register on the next cycle, so a request can be accepted on every cycle:
// one per clock while the receiver takes responses, set by the single output register.
// The output register is freed in the same cycle it is taken, so req_tready is only low
// while a response is waiting and the receiver holds rsp_tready low; the stalled response
// then stays put and no new request is taken until it leaves. The csr_ port sets the
// program bank count and whether character ROM is present, in effect from the next mapper
// reset; the user must write it only while the block is idle, which the block does not
// enforce. A synchronous reset loads the default banks (CPU 0, 1, count-2, count-1 for
// a count of 32, character banks 0 to 7), clears mirroring, the counter, latch and
// enable, and empties the output register; no clearing pass holds up requests after it.

module scanline_irq_bank_mapper
   import slibm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] address, [23:16] data, [27:24] bank_slot, zero fill
   input  logic [1:0]  req_tuser,   // [1:0] command
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] irq_pulse, [2:1] mirror_mode, [10:3] bank_value,
                                    // [11] irq_armed, zero fill
   // Configuration port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   // Configuration registers
   logic [8:0] prg_count_ff;
   logic       chr_present_ff;

   // Mapper state
   logic [7:0] cpu_bank_ff [4];
   logic [7:0] cpu_bank_in [4];
   logic [7:0] chr_bank_ff [8];
   logic [7:0] chr_bank_in [8];
   logic [1:0] mirror_ff, mirror_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [1:0]  command;
   logic [15:0] address;
   logic [7:0]  data;
   logic [3:0]  slot;
   logic [7:0]  bank_value;
   logic        is_write;

   irq_ctl_type  irq_ctl;
   irq_stat_type irq_stat;

   assign command = req_tuser;
   assign address = req_tdata[15:0];
   assign data    = req_tdata[23:16];
   assign slot    = req_tdata[27:24];

   // A waiting response that is being taken frees the register for a new one.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_write   = accept && (command == CMD_BUS_WRITE);

   // Strobes for the interrupt counter.
   always_comb begin
      irq_ctl.clear   = accept && (command == CMD_RESET);
      irq_ctl.disarm  = is_write && (address == ADDR_IRQ_DISABLE);
      irq_ctl.load_lo = is_write && (address == ADDR_LATCH_LO);
      irq_ctl.load_hi = is_write && (address == ADDR_LATCH_HI);
      irq_ctl.tick    = accept && (command == CMD_SCANLINE);
   end

   slibm_irq_counter u_irq (
      .clock (clock),
      .reset (reset),
      .ctl   (irq_ctl),
      .data  (data),
      .stat  (irq_stat)
   );

   // Bank and mirroring updates. The CPU banks sit at four consecutive addresses and the
   // character banks at eight, so the low address bits select the register.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cpu_bank_in[i] = cpu_bank_ff[i];
      end
      for (int i = 0; i < 8; i++) begin
         chr_bank_in[i] = chr_bank_ff[i];
      end
      mirror_in = mirror_ff;
      if (is_write) begin
         if (address[15:2] == ADDR_CPU_BANK_BASE[15:2]) begin
            cpu_bank_in[address[1:0]] = data;
         end else if (address[15:3] == ADDR_CHR_BANK_BASE[15:3]) begin
            chr_bank_in[address[2:0]] = data;
         end else if (address == ADDR_MIRROR_SINGLE) begin
            mirror_in = data[4] ? MIRROR_SINGLE_B : MIRROR_SINGLE_A;
         end else if (address == ADDR_MIRROR_DUAL) begin
            mirror_in = data[4] ? MIRROR_HORIZ : MIRROR_VERTICAL;
         end
      end else if (irq_ctl.clear) begin
         // Mapper reset reloads default banks (character only with ROM), keeps mirroring.
         cpu_bank_in[0] = 8'd0;
         cpu_bank_in[1] = 8'd1;
         cpu_bank_in[2] = prg_count_ff[7:0] - 8'd2;
         cpu_bank_in[3] = prg_count_ff[7:0] - 8'd1;
         if (chr_present_ff) begin
            for (int i = 0; i < 8; i++) begin
               chr_bank_in[i] = 8'(i);
            end
         end
      end
   end

   // Query read: slots 0 to 3 are CPU banks, 4 to 11 character banks, others read zero.
   always_comb begin
      bank_value = 8'd0;
      if (command == CMD_QUERY) begin
         if (slot < 4'd4) begin
            bank_value = cpu_bank_ff[slot[1:0]];
         end else if (slot < 4'd12) begin
            bank_value = chr_bank_ff[3'(slot - 4'd4)];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {irq_stat.armed, bank_value, mirror_in, irq_stat.pulse};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= PRG_BANK_COUNT_RESET;
         chr_present_ff <= CHR_ROM_PRESENT_RESET;
         cpu_bank_ff[0] <= 8'd0;
         cpu_bank_ff[1] <= 8'd1;
         cpu_bank_ff[2] <= PRG_BANK_COUNT_RESET[7:0] - 8'd2;
         cpu_bank_ff[3] <= PRG_BANK_COUNT_RESET[7:0] - 8'd1;
         for (int i = 0; i < 8; i++) begin
            chr_bank_ff[i] <= 8'(i);
         end
         mirror_ff    <= MIRROR_SINGLE_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PRG_BANK_COUNT:  prg_count_ff   <= csr_wdata;
               CSR_CHR_ROM_PRESENT: chr_present_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         cpu_bank_ff  <= cpu_bank_in;
         chr_bank_ff  <= chr_bank_in;
         mirror_ff    <= mirror_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");
   a_pulse_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> !rsp_data_ff[11])
      else $error("interrupt pulse reported with counting still enabled");
   a_query_only: assert property (@(posedge clock) disable iff (reset)
      (accept && (command != CMD_QUERY)) |=> (rsp_data_ff[10:3] == 8'd0))
      else $error("bank value nonzero on a request that is not a query");
`endif

endmodule
